### rtl/core/utf8_text_validator_defines.svh
// ----------------------------------------------------------------------------
// utf8_text_validator_defines.svh
// Assertion macros shared by the validator's checker.
// ----------------------------------------------------------------------------
`ifndef UTF8_TEXT_VALIDATOR_DEFINES_SVH
`define UTF8_TEXT_VALIDATOR_DEFINES_SVH

// Clocked check, muted while reset is held
`define UTF8V_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds across reset
`define UTF8V_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/utf8v_pkg.sv
// ----------------------------------------------------------------------------
// utf8v_pkg
// Types and constants shared by the UTF-8 text validator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package utf8v_pkg;

  // Length checking
  localparam int LENGTH_BITS = 16;
  localparam int CNT_W       = LENGTH_BITS + 1;
  localparam int CFG_W       = 16;
  localparam logic [CFG_W-1:0] MAX_LENGTH_RST = '1;

  // Code point accumulator
  localparam int ACC_W = 21;
  localparam logic [ACC_W-1:0] CP_MIN_3BYTE  = ACC_W'(24'h000800);
  localparam logic [ACC_W-1:0] CP_MIN_4BYTE  = ACC_W'(24'h010000);
  localparam logic [ACC_W-1:0] CP_SURR_LO    = ACC_W'(24'h00D800);
  localparam logic [ACC_W-1:0] CP_SURR_HI    = ACC_W'(24'h00DFFF);
  localparam logic [ACC_W-1:0] CP_MAX        = ACC_W'(24'h10FFFF);
  localparam logic [ACC_W-1:0] CP_C1_LO      = ACC_W'(24'h000080);
  localparam logic [ACC_W-1:0] CP_C1_HI      = ACC_W'(24'h00009F);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Byte classes found by the front
  typedef enum logic [2:0] {
    KIND_ASCII,
    KIND_CTRL,
    KIND_LEAD2,
    KIND_LEAD3,
    KIND_LEAD4,
    KIND_CONT,
    KIND_INVALID
  } byte_kind_t;

  // Result codes
  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_LENGTH,
    STATUS_ENCODING,
    STATUS_CONTROL
  } status_t;

  // One classified beat in the queue
  typedef struct packed {
    logic       has_byte;
    logic       end_of_text;
    byte_kind_t kind;
    logic [5:0] bits;
  } beat_t;

  // Length limit from the register: only its low LENGTH_BITS bits count
  function automatic logic [CNT_W-1:0] len_limit(input logic [CFG_W-1:0] m);
    logic [CNT_W-1:0] r;
    r = '0;
    for (int i = 0; i < LENGTH_BITS; i++) begin
      if (i < CFG_W) r[i] = m[i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/utf8v_if.sv
// ----------------------------------------------------------------------------
// utf8v_if
// Valid/ready channels of the validator: byte input, status output, config.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface utf8v_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_text;
  logic       empty_text;

  modport source (output valid, output data_byte, output end_of_text,
                  output empty_text, input ready);
  modport sink   (input valid, input data_byte, input end_of_text,
                  input empty_text, output ready);
endinterface

interface utf8v_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;

  modport source (output valid, output status, input ready);
  modport sink   (input valid, input status, output ready);
endinterface

interface utf8v_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] max_length;

  modport source (output valid, output max_length, input ready);
  modport sink   (input valid, input max_length, output ready);
endinterface

`default_nettype wire

### rtl/core/utf8v_front.sv
// ----------------------------------------------------------------------------
// utf8v_front
// Accepts input beats and classifies each byte for the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf8v_front
  import utf8v_pkg::*;
(
  utf8v_in_if.sink in_bus,
  output logic     push_valid,
  input  logic     push_ready,
  output beat_t    push_beat
);

  logic [7:0] b;

  assign b            = in_bus.data_byte;
  assign in_bus.ready = push_ready;
  assign push_valid   = in_bus.valid;

  // Byte class and payload bits; lead-byte range checks are stateless
  always_comb begin
    push_beat.has_byte    = !in_bus.empty_text;
    push_beat.end_of_text = in_bus.end_of_text;
    push_beat.kind        = KIND_ASCII;
    push_beat.bits        = '0;
    if (in_bus.empty_text) begin
      push_beat.kind = KIND_ASCII;
    end else if (!b[7]) begin
      // C0 controls and DEL
      if (b < 8'h20 || b == 8'h7F) push_beat.kind = KIND_CTRL;
      else                         push_beat.kind = KIND_ASCII;
    end else if ((b & 8'hC0) == 8'h80) begin
      push_beat.kind = KIND_CONT;
      push_beat.bits = b[5:0];
    end else if ((b & 8'hE0) == 8'hC0) begin
      // C0/C1 leads are always overlong
      if (b[4:0] < 5'd2) begin
        push_beat.kind = KIND_INVALID;
      end else begin
        push_beat.kind = KIND_LEAD2;
        push_beat.bits = {1'b0, b[4:0]};
      end
    end else if ((b & 8'hF0) == 8'hE0) begin
      push_beat.kind = KIND_LEAD3;
      push_beat.bits = {2'b00, b[3:0]};
    end else if ((b & 8'hF8) == 8'hF0) begin
      // F5..F7 start values beyond the code space
      if (b[2:0] > 3'd4) begin
        push_beat.kind = KIND_INVALID;
      end else begin
        push_beat.kind = KIND_LEAD4;
        push_beat.bits = {3'b000, b[2:0]};
      end
    end else begin
      push_beat.kind = KIND_INVALID;
    end
  end

endmodule

`default_nettype wire

### rtl/core/utf8v_queue.sv
// ----------------------------------------------------------------------------
// utf8v_queue
// Small FIFO of classified beats between the front and the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf8v_queue
  import utf8v_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  beat_t push_beat,
  output logic  pop_valid,
  input  logic  pop_ready,
  output beat_t pop_beat
);

  beat_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_beat   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop)      count_nxt = count_r + 1'b1;
    else if (!do_push && do_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_beat;
  end

endmodule

`default_nettype wire

### rtl/core/utf8v_back.sv
// ----------------------------------------------------------------------------
// utf8v_back
// Decode state, error flags, length counter and the status output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf8v_back
  import utf8v_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  beat_t      pop_beat,
  utf8v_cfg_if.sink  cfg_bus,
  utf8v_out_if.source out_bus
);

  logic [CFG_W-1:0] cfg_max_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       pend_r, pend_nxt;
  logic [1:0]       seq_r, seq_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic             len_err_r, len_err_nxt;
  logic             enc_err_r, enc_err_nxt;
  logic             ctl_err_r, ctl_err_nxt;
  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;

  logic             take;
  logic [ACC_W-1:0] acc_shift;
  logic             bad_cp;
  logic             bad;
  logic             enc_final;

  // Config register, always ready
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n)             cfg_max_r <= MAX_LENGTH_RST;
    else if (cfg_bus.valid) cfg_max_r <= cfg_bus.max_length;
  end

  // Ending beats need a free output slot; other beats always drain
  assign pop_ready = !pop_beat.end_of_text || !out_valid_r || out_bus.ready;
  assign take      = pop_valid && pop_ready;

  // Continuation merge and code point range checks
  assign acc_shift = {acc_r[ACC_W-7:0], pop_beat.bits};
  assign bad_cp    = (seq_r == 2'd2 && acc_shift < CP_MIN_3BYTE) ||
                     (seq_r == 2'd3 && acc_shift < CP_MIN_4BYTE) ||
                     (acc_shift >= CP_SURR_LO && acc_shift <= CP_SURR_HI) ||
                     (acc_shift > CP_MAX);

  // Decoder state update
  always_comb begin
    cnt_nxt        = cnt_r;
    pend_nxt       = pend_r;
    seq_nxt        = seq_r;
    acc_nxt        = acc_r;
    len_err_nxt    = len_err_r;
    enc_err_nxt    = enc_err_r;
    ctl_err_nxt    = ctl_err_r;
    out_valid_nxt  = out_valid_r && !out_bus.ready;
    out_status_nxt = out_status_r;
    bad            = 1'b0;
    enc_final      = 1'b0;
    if (take) begin
      if (pop_beat.has_byte) begin
        // saturating byte count and length check
        if (cnt_r != '1) cnt_nxt = cnt_r + 1'b1;
        if (cnt_nxt > len_limit(cfg_max_r)) len_err_nxt = 1'b1;
        if (!enc_err_r) begin
          if (pend_r == 2'd0) begin
            case (pop_beat.kind)
              KIND_ASCII: ;
              KIND_CTRL:  ctl_err_nxt = 1'b1;
              KIND_LEAD2: begin
                pend_nxt = 2'd1;
                seq_nxt  = 2'd1;
                acc_nxt  = ACC_W'(pop_beat.bits);
              end
              KIND_LEAD3: begin
                pend_nxt = 2'd2;
                seq_nxt  = 2'd2;
                acc_nxt  = ACC_W'(pop_beat.bits);
              end
              KIND_LEAD4: begin
                pend_nxt = 2'd3;
                seq_nxt  = 2'd3;
                acc_nxt  = ACC_W'(pop_beat.bits);
              end
              default: bad = 1'b1;
            endcase
          end else if (pop_beat.kind != KIND_CONT) begin
            bad = 1'b1;
          end else begin
            acc_nxt  = acc_shift;
            pend_nxt = pend_r - 1'b1;
            // last continuation completes the code point
            if (pend_r == 2'd1) begin
              if (bad_cp) begin
                bad = 1'b1;
              end else begin
                if (acc_shift >= CP_C1_LO && acc_shift <= CP_C1_HI) ctl_err_nxt = 1'b1;
                seq_nxt = 2'd0;
                acc_nxt = '0;
              end
            end
          end
          if (bad) begin
            enc_err_nxt = 1'b1;
            pend_nxt    = 2'd0;
            seq_nxt     = 2'd0;
            acc_nxt     = '0;
          end
        end
      end
      // end of text: report and clear for the next text
      if (pop_beat.end_of_text) begin
        enc_final     = enc_err_nxt || (pend_nxt != 2'd0);
        out_valid_nxt = 1'b1;
        if (len_err_nxt)      out_status_nxt = STATUS_LENGTH;
        else if (enc_final)   out_status_nxt = STATUS_ENCODING;
        else if (ctl_err_nxt) out_status_nxt = STATUS_CONTROL;
        else                  out_status_nxt = STATUS_OK;
        cnt_nxt     = '0;
        pend_nxt    = 2'd0;
        seq_nxt     = 2'd0;
        acc_nxt     = '0;
        len_err_nxt = 1'b0;
        enc_err_nxt = 1'b0;
        ctl_err_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pend_r      <= '0;
      seq_r       <= '0;
      acc_r       <= '0;
      len_err_r   <= 1'b0;
      enc_err_r   <= 1'b0;
      ctl_err_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      seq_r       <= seq_nxt;
      acc_r       <= acc_nxt;
      len_err_r   <= len_err_nxt;
      enc_err_r   <= enc_err_nxt;
      ctl_err_r   <= ctl_err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Status payload
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
  end

  assign out_bus.valid  = out_valid_r;
  assign out_bus.status = out_status_r;

endmodule

`default_nettype wire

### rtl/core/utf8_text_validator.sv
// ----------------------------------------------------------------------------
// utf8_text_validator
// UTF-8 text validator: one status per text, byte-serial input.
// ----------------------------------------------------------------------------
// Takes one byte beat per cycle while the queue has room and returns one status
// beat for each beat that ends a text (0 ok, 1 length exceeded, 2 invalid
// UTF-8, 3 control character). Sustained rate is one beat per clock unless a
// waiting status holds back an ending beat. The front classifies each byte into
// a 4-entry queue, and the decoder drains it into a registered status output,
// so a status passes through a queue entry and the status register. The input
// keeps accepting while a status waits to be taken until the queue fills.
// max_length should be written only while no text is in flight.
`timescale 1ns / 1ps
`default_nettype none

module utf8_text_validator
  import utf8v_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  utf8v_in_if.sink    in_bus,
  utf8v_out_if.source out_bus,
  utf8v_cfg_if.sink   cfg_bus
);

  logic  push_valid, push_ready;
  beat_t push_beat;
  logic  pop_valid, pop_ready;
  beat_t pop_beat;

  // Byte classification
  utf8v_front u_front (
    .in_bus     (in_bus),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_beat  (push_beat)
  );

  // Decoupling queue
  utf8v_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_beat  (push_beat),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_beat   (pop_beat)
  );

  // Decoder and status output
  utf8v_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_beat  (pop_beat),
    .cfg_bus   (cfg_bus),
    .out_bus   (out_bus)
  );

endmodule

`default_nettype wire

### rtl/core/utf8v_checker.sv
// ----------------------------------------------------------------------------
// utf8v_checker
// Port-level checks for the validator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "utf8_text_validator_defines.svh"

module utf8v_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       in_valid,
  input wire       in_ready,
  input wire       in_end,
  input wire       out_valid,
  input wire       out_ready,
  input wire [1:0] out_status
);

  logic [3:0] open_r, open_nxt;
  logic       end_beat, out_beat;

  assign end_beat = in_valid && in_ready && in_end;
  assign out_beat = out_valid && out_ready;

  // Texts ended at the input but not yet reported
  always_comb begin
    open_nxt = open_r;
    if (end_beat && !out_beat)      open_nxt = open_r + 1'b1;
    else if (!end_beat && out_beat) open_nxt = open_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) open_r <= '0;
    else        open_r <= open_nxt;
  end

  `UTF8V_ASSERT_RST(a_quiet_after_reset, !rst_n |=> !out_valid, "status valid after reset")
  `UTF8V_ASSERT(a_status_has_text, out_valid |-> open_r != 4'd0, "status without ended text")
  `UTF8V_ASSERT(a_valid_holds, out_valid && !out_ready |=> out_valid, "status dropped while stalled")
  `UTF8V_ASSERT(a_status_holds, out_valid && !out_ready |=> $stable(out_status), "status changed while stalled")

endmodule

bind utf8_text_validator utf8v_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_bus.valid),
  .in_ready   (in_bus.ready),
  .in_end     (in_bus.end_of_text),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .out_status (out_bus.status)
);

`default_nettype wire
